// File: rtl/core/ebi_pkg.sv
`timescale 1ns / 1ps

package ebi_pkg;

    localparam int IDX_W     = 4;
    localparam int POS_W     = 32;
    localparam int AMP_W     = 16;
    localparam int PROD_W    = POS_W + AMP_W;
    localparam int STEP_W    = 4;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [STEP_W-1:0] STEP_LAST = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_FINISH
    } ebi_state_t;

endpackage

// File: rtl/core/envelope_breakpoint_interpolator.sv
`timescale 1ns / 1ps

// Envelope breakpoint interpolator. A request with tuser low writes one breakpoint (position,
// amplitude) into a small table; it gives no result. A request with tuser high queries the
// amplitude at a position: the table is read one entry per clock cycle from entry 0 until the
// first breakpoint at or after the query, or until the last breakpoint set by cfg_wr_data. A
// hit on entry 0, or a query past the end, then goes to the finish state, which loads the
// output register; any other hit first interpolates linearly with a bit-serial shift-add
// multiply, a restoring divide and an add step. No new request is taken until the query has
// left the finish state. The result sits in an output register, so the next request is taken
// while it waits; a query that finishes while that register is still full waits until it
// drains. Table entries hold no reset value and must be written before a query reaches them.
module envelope_breakpoint_interpolator
    import ebi_pkg::*;
#(
    parameter int BREAKPOINTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index[3:0], position[35:4], amplitude_in[51:36], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // amplitude_out[15:0]
    output logic [M_TDATA_W-1:0] m_tdata,
    // past_end
    output logic                 m_tuser
);

    localparam int AW = (BREAKPOINTS > 1) ? $clog2(BREAKPOINTS) : 1;

    logic [POS_W-1:0] pos_mem [BREAKPOINTS];
    logic [AMP_W-1:0] amp_mem [BREAKPOINTS];

    ebi_state_t state_reg, state_next;
    logic [IDX_W-1:0]  last_bp_reg, last_bp_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [AMP_W-1:0]  m_amp_reg, m_amp_next;
    logic              m_past_reg, m_past_next;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  lim_reg, lim_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]  query_reg, query_next;
    logic [POS_W-1:0]  prev_pos_reg, prev_pos_next;
    logic [AMP_W-1:0]  prev_amp_reg, prev_amp_next;
    logic [POS_W-1:0]  n_reg, n_next;
    logic [POS_W-1:0]  d_reg, d_next;
    logic [AMP_W-1:0]  a1_reg, a1_next;
    logic              neg_reg, neg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [AMP_W-1:0]  res_amp_reg, res_amp_next;
    logic              res_past_reg, res_past_next;

    logic [POS_W-1:0] rd_pos_reg;
    logic [AMP_W-1:0] rd_amp_reg;
    logic [IDX_W-1:0] rd_idx;

    logic [IDX_W-1:0] in_index;
    logic [POS_W-1:0] in_pos;
    logic [AMP_W-1:0] in_amp;
    logic             in_accept;
    logic             out_free;
    logic             hit;
    logic [AMP_W-1:0] amp_diff;
    logic [POS_W:0]   mul_sum;
    logic [POS_W:0]   div_trial;
    logic             div_ge;
    logic [POS_W:0]   div_rem;

    assign in_index  = s_tdata[IDX_W-1:0];
    assign in_pos    = s_tdata[IDX_W+POS_W-1:IDX_W];
    assign in_amp    = s_tdata[IDX_W+POS_W+AMP_W-1:IDX_W+POS_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_amp_reg;
    assign m_tuser  = m_past_reg;

    // table write and registered read
    assign rd_idx = (state_reg == ST_SCAN) ? idx_next : '0;

    always_ff @(posedge aclk) begin
        if (in_accept && s_tuser == FUNC_WRITE && 32'(in_index) < BREAKPOINTS) begin
            pos_mem[AW'(in_index)] <= in_pos;
            amp_mem[AW'(in_index)] <= in_amp;
        end
        rd_pos_reg <= pos_mem[AW'(rd_idx)];
        rd_amp_reg <= amp_mem[AW'(rd_idx)];
    end

    assign hit      = rd_pos_reg >= query_reg;
    assign amp_diff = (rd_amp_reg >= prev_amp_reg) ? rd_amp_reg - prev_amp_reg
                                                   : prev_amp_reg - rd_amp_reg;

    // shift-add multiply, one multiplier bit per cycle
    assign mul_sum = {1'b0, prod_reg[PROD_W-1:AMP_W]}
                   + (prod_reg[0] ? {1'b0, n_reg} : {(POS_W+1){1'b0}});

    // restoring divide, one quotient bit per cycle
    assign div_trial = {prod_reg[PROD_W-1:AMP_W], prod_reg[AMP_W-1]};
    assign div_ge    = div_trial >= {1'b0, d_reg};
    assign div_rem   = div_ge ? div_trial - {1'b0, d_reg} : div_trial;

    always_comb begin
        state_next    = state_reg;
        last_bp_next  = last_bp_reg;
        m_tvalid_next = m_tvalid_reg;
        m_amp_next    = m_amp_reg;
        m_past_next   = m_past_reg;
        idx_next      = idx_reg;
        lim_next      = lim_reg;
        cnt_next      = cnt_reg;
        query_next    = query_reg;
        prev_pos_next = prev_pos_reg;
        prev_amp_next = prev_amp_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        a1_next       = a1_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        res_amp_next  = res_amp_reg;
        res_past_next = res_past_reg;

        if (cfg_wr_en) begin
            last_bp_next = cfg_wr_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && s_tuser == FUNC_QUERY) begin
                    query_next = in_pos;
                    idx_next   = '0;
                    lim_next   = (32'(last_bp_reg) >= BREAKPOINTS) ?
                                 IDX_W'(BREAKPOINTS - 1) : last_bp_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit && idx_reg == '0) begin
                    res_amp_next  = rd_amp_reg;
                    res_past_next = 1'b0;
                    state_next    = ST_FINISH;
                end else if (hit) begin
                    n_next        = query_reg - prev_pos_reg;
                    d_next        = rd_pos_reg - prev_pos_reg;
                    a1_next       = prev_amp_reg;
                    neg_next      = rd_amp_reg < prev_amp_reg;
                    prod_next     = {{POS_W{1'b0}}, amp_diff};
                    cnt_next      = '0;
                    res_past_next = 1'b0;
                    state_next    = ST_MUL;
                end else if (idx_reg == lim_reg) begin
                    res_amp_next  = rd_amp_reg;
                    res_past_next = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    prev_pos_next = rd_pos_reg;
                    prev_amp_next = rd_amp_reg;
                    idx_next      = idx_reg + 1'b1;
                end
            end
            ST_MUL: begin
                prod_next = {mul_sum, prod_reg[AMP_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                prod_next = {div_rem[POS_W-1:0], prod_reg[AMP_W-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                res_amp_next = neg_reg ? a1_reg - prod_reg[AMP_W-1:0]
                                       : a1_reg + prod_reg[AMP_W-1:0];
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_amp_next    = res_amp_reg;
                    m_past_next   = res_past_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_bp_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_bp_reg  <= last_bp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_amp_reg    <= m_amp_next;
        m_past_reg   <= m_past_next;
        idx_reg      <= idx_next;
        lim_reg      <= lim_next;
        cnt_reg      <= cnt_next;
        query_reg    <= query_next;
        prev_pos_reg <= prev_pos_next;
        prev_amp_reg <= prev_amp_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        a1_reg       <= a1_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        res_amp_reg  <= res_amp_next;
        res_past_reg <= res_past_next;
    end

    // a finished result waits while the output register is still full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_tvalid_reg && !m_tready) |=> (state_reg == ST_FINISH))
        else $error("result left finish state while output was full");

    // a new result only comes out of the finish state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && state_reg != ST_FINISH) |=> !m_tvalid_reg)
        else $error("result appeared without a finished query");

    // serial arithmetic always starts from step zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && state_next == ST_MUL) |=> (cnt_reg == '0))
        else $error("multiply started with a stale step count");

endmodule

// File: tb/sv/tb_envelope_breakpoint_interpolator.sv
`timescale 1ns / 1ps

module tb_envelope_breakpoint_interpolator;
    import ebi_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 130;

    typedef struct packed {
        logic [AMP_W-1:0] amp;
        logic             past;
    } amp_result_t;

    class envelope_scoreboard;
        logic [POS_W-1:0] bp_pos[16];
        logic [AMP_W-1:0] bp_amp[16];
        logic [IDX_W-1:0] last_bp;
        amp_result_t      amp_expected[$];
        int               errors;

        function new();
            last_bp = '0;
            errors  = 0;
        endfunction

        function void set_last(logic [IDX_W-1:0] v);
            last_bp = v;
        endfunction

        function int pending();
            return amp_expected.size();
        endfunction

        function amp_result_t interpolate_amp(logic [POS_W-1:0] query);
            amp_result_t r;
            logic        hit;
            logic [63:0] n, d, span, q;
            logic [AMP_W-1:0] a1, a2;
            r.amp  = bp_amp[last_bp];
            r.past = 1'b1;
            hit    = 1'b0;
            for (int i = 0; i < 16; i++) begin
                if (!hit && i <= int'(last_bp) && bp_pos[i] >= query) begin
                    hit    = 1'b1;
                    r.past = 1'b0;
                    if (i == 0) begin
                        r.amp = bp_amp[0];
                    end else begin
                        a1   = bp_amp[i-1];
                        a2   = bp_amp[i];
                        n    = {32'b0, query - bp_pos[i-1]};
                        d    = {32'b0, bp_pos[i] - bp_pos[i-1]};
                        span = (a2 >= a1) ? {48'b0, a2 - a1} : {48'b0, a1 - a2};
                        q    = (span * n) / d;
                        r.amp = (a2 >= a1) ? a1 + q[AMP_W-1:0] : a1 - q[AMP_W-1:0];
                    end
                end
            end
            return r;
        endfunction

        function void note_request(logic func, logic [IDX_W-1:0] idx,
                                   logic [POS_W-1:0] pos, logic [AMP_W-1:0] amp);
            if (func == FUNC_WRITE) begin
                bp_pos[idx] = pos;
                bp_amp[idx] = amp;
            end else begin
                amp_expected.push_back(interpolate_amp(pos));
            end
        endfunction

        function void check_result(logic [AMP_W-1:0] amp, logic past);
            amp_result_t want;
            if (amp_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result amp=%h past_end=%b", amp, past);
            end else begin
                want = amp_expected.pop_front();
                if (amp !== want.amp || past !== want.past) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch amp exp=%h got=%h past_end exp=%b got=%b",
                                 want.amp, amp, want.past, past);
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [IDX_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    envelope_scoreboard sb;
    int                 cycle_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_req;
    int                 hold_left;
    logic [POS_W-1:0]   table_pos[16];
    logic [IDX_W-1:0]   cur_last;

    envelope_breakpoint_interpolator #(
        .BREAKPOINTS(16)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver with random stalls and an on-demand long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            if (aresetn && s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[51:36]);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    task automatic push_request(logic func, logic [IDX_W-1:0] idx,
                                logic [POS_W-1:0] pos, logic [AMP_W-1:0] amp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, amp, pos, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic load_point(logic [IDX_W-1:0] idx, logic [POS_W-1:0] pos,
                              logic [AMP_W-1:0] amp);
        table_pos[idx] = pos;
        push_request(FUNC_WRITE, idx, pos, amp);
    endtask

    task automatic ask_amplitude(logic [POS_W-1:0] pos);
        push_request(FUNC_QUERY, IDX_W'($urandom), pos, AMP_W'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic set_last_breakpoint(logic [IDX_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_last(v);
        cur_last = v;
    endtask

    // sorted table with random spacing, now and then a repeated position
    task automatic load_sorted_table();
        logic [32:0]      p;
        logic [POS_W-1:0] smax;
        logic [AMP_W-1:0] a;
        int               kind;
        kind = $urandom_range(2);
        smax = (kind == 0) ? 32'h40 : (kind == 1) ? 32'h00FF_FFFF : 32'h0FFF_FFFF;
        p    = ($urandom_range(3) == 0) ? 33'd0 : {1'b0, 32'($urandom_range(32'h7FFF_FFFF))};
        for (int i = 0; i < 16; i++) begin
            case ($urandom_range(7))
                0: a = '0;
                1: a = '1;
                default: a = AMP_W'($urandom);
            endcase
            load_point(IDX_W'(i), p[31:0], a);
            if ($urandom_range(9) != 0)
                p = p + {1'b0, 32'($urandom_range(smax, 1))};
            if (p[32])
                p = {1'b0, 32'hFFFF_FFFF};
        end
    endtask

    task automatic random_item();
        logic [POS_W-1:0] p1, p2, q;
        int               i, pick;
        pick = $urandom_range(99);
        if (pick < 55 && cur_last != 0) begin
            i  = $urandom_range(int'(cur_last), 1);
            p1 = table_pos[i-1];
            p2 = table_pos[i];
            q  = (p2 > p1) ? p1 + 1 + ($urandom % (p2 - p1)) : p2;
            ask_amplitude(q);
        end else if (pick < 65) begin
            ask_amplitude(table_pos[$urandom_range(int'(cur_last))]);
        end else if (pick < 72) begin
            p1 = table_pos[0];
            ask_amplitude((p1 == 0) ? 32'd0 : $urandom % p1);
        end else if (pick < 80) begin
            p2 = table_pos[cur_last];
            ask_amplitude((p2 == '1) ? p2 : p2 + 1 + ($urandom % (~p2)));
        end else if (pick < 90) begin
            ask_amplitude($urandom);
        end else begin
            load_point(IDX_W'($urandom), $urandom, AMP_W'($urandom));
        end
    endtask

    initial begin
        sb             = new();
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_WRITE;
        m_tready       = 1'b0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        cur_last       = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-entry table: hit on entry 0 and past the end
        load_point(4'd0, 32'd0, 16'hFFFF);
        ask_amplitude(32'd0);
        ask_amplitude(32'hFFFF_FFFF);

        set_last_breakpoint(4'd15);
        for (int i = 1; i < 16; i++)
            load_point(IDX_W'(i), (i == 15) ? 32'hFFFF_FFFF : 32'(i) * 32'h1000_0000,
                       (i == 15) ? 16'h8000 : (i % 2 == 1) ? 16'h0000 : 16'hFFFF);
        ask_amplitude(32'h0000_8000);
        ask_amplitude(32'h1000_0000);
        ask_amplitude(32'h1800_0000);
        ask_amplitude(32'hFFFF_FFFE);
        ask_amplitude(32'hFFFF_FFFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (ph == 1 || ph == 8)
                set_last_breakpoint(4'd0);
            else if (ph % 3 == 0)
                set_last_breakpoint(4'd15);
            else
                set_last_breakpoint(IDX_W'($urandom_range(14, 1)));
            load_sorted_table();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == 10)
                    hold_req = 1'b1;
                if (ph == 3 && k == 65)
                    drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/ebi_pkg.sv
rtl/core/envelope_breakpoint_interpolator.sv
tb/sv/tb_envelope_breakpoint_interpolator.sv
